/* hdl/lrlte_pkg.sv */
// shared types and constants for the level run-length tape encoder
`default_nettype none
package lrlte_pkg;

   localparam int MAX_WORDS_PER_RUN = 64;
   localparam int CHUNK_LIMIT       = 32767;
   localparam int TICK_CAP          = MAX_WORDS_PER_RUN * CHUNK_LIMIT;

   localparam int TPS_WIDTH     = 22;
   localparam int RUN_WIDTH     = 24;
   localparam int SAMPLES_WIDTH = RUN_WIDTH + 1;
   localparam int PROD_WIDTH    = SAMPLES_WIDTH + TPS_WIDTH;
   localparam int FRAC_BITS     = 16;
   localparam int TICKS_WIDTH   = PROD_WIDTH - FRAC_BITS;
   localparam int WORD_WIDTH    = 16;
   localparam int DUR_WIDTH     = 15;

   localparam logic [TPS_WIDTH-1:0] TPS_RESET = 22'd165120;
   localparam logic [RUN_WIDTH-1:0] RUN_MAX   = {RUN_WIDTH{1'b1}};

   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam logic CSR_IDX_TPS  = 1'b0;

   typedef struct packed {
      logic [SAMPLES_WIDTH-1:0] samples;
      logic                     level;
   } run_entry_type;

   typedef enum logic [2:0] {
      BK_IDLE  = 3'b001,
      BK_SPLIT = 3'b010,
      BK_EMIT  = 3'b100
   } back_state_type;

endpackage
`default_nettype wire

/* hdl/lrlte_front.sv */
// front end: tracks the level and counts run lengths, pushes finished runs
`default_nettype none
module lrlte_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic                   req_level,
   output logic                        push_valid,
   input  wire logic                   push_ready,
   output lrlte_pkg::run_entry_type    push_entry
);
   import lrlte_pkg::*;

   logic                 previous_level_ff, previous_level_in;
   logic [RUN_WIDTH-1:0] run_samples_ff, run_samples_in;
   logic                 accept;
   logic                 change;

   assign req_ready  = push_ready;
   assign accept     = req_valid && req_ready;
   assign change     = req_level != previous_level_ff;
   assign push_valid = accept && change;

   assign push_entry.samples = {1'b0, run_samples_ff} + SAMPLES_WIDTH'(1);
   assign push_entry.level   = req_level;

   always_comb begin
      previous_level_in = previous_level_ff;
      run_samples_in    = run_samples_ff;
      if (accept) begin
         if (change) begin
            previous_level_in = req_level;
            run_samples_in    = '0;
         end else if (run_samples_ff != RUN_MAX) begin
            run_samples_in = run_samples_ff + RUN_WIDTH'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         previous_level_ff <= 1'b0;
         run_samples_ff    <= '0;
      end else begin
         previous_level_ff <= previous_level_in;
         run_samples_ff    <= run_samples_in;
      end
   end

endmodule
`default_nettype wire

/* hdl/lrlte_queue.sv */
// two-entry queue of finished runs between front and back
`default_nettype none
module lrlte_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push_valid,
   output logic                        push_ready,
   input  wire lrlte_pkg::run_entry_type push_entry,
   output logic                        pop_valid,
   input  wire logic                   pop_ready,
   output lrlte_pkg::run_entry_type    pop_entry
);
   import lrlte_pkg::*;

   run_entry_type entries_ff [2];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    count_ff, count_in;
   logic          do_push, do_pop;

   assign push_ready = count_ff != 2'd2;
   assign pop_valid  = count_ff != 2'd0;
   assign pop_entry  = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule
`default_nettype wire

/* hdl/lrlte_back.sv */
// back end: scales a run to ticks and splits it into tape words
`default_nettype none
module lrlte_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [lrlte_pkg::TPS_WIDTH-1:0] ticks_per_sample,
   input  wire logic                          pop_valid,
   output logic                               pop_ready,
   input  wire lrlte_pkg::run_entry_type      pop_entry,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [lrlte_pkg::WORD_WIDTH-1:0]   rsp_tape_word,
   output logic                               rsp_last
);
   import lrlte_pkg::*;

   back_state_type         state_ff, state_in;
   logic [PROD_WIDTH-1:0]  product_ff, product_in;
   logic                   level_ff, level_in;
   logic [TPS_WIDTH-1:0]   ticks_left_ff, ticks_left_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [WORD_WIDTH-1:0]  rsp_tape_word_ff, rsp_tape_word_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic [TICKS_WIDTH-1:0] ticks_full;
   logic [TPS_WIDTH-1:0]   ticks_sat;
   logic                   slot_free;
   logic                   final_chunk;
   logic [DUR_WIDTH-1:0]   chunk;

   assign pop_ready     = state_ff == BK_IDLE;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_tape_word = rsp_tape_word_ff;
   assign rsp_last      = rsp_last_ff;

   assign ticks_full  = product_ff[PROD_WIDTH-1:FRAC_BITS];
   assign ticks_sat   = (ticks_full > TICKS_WIDTH'(TICK_CAP)) ? TPS_WIDTH'(TICK_CAP)
                                                               : ticks_full[TPS_WIDTH-1:0];
   assign slot_free   = !rsp_valid_ff || rsp_ready;
   assign final_chunk = ticks_left_ff <= TPS_WIDTH'(CHUNK_LIMIT);
   assign chunk       = final_chunk ? ticks_left_ff[DUR_WIDTH-1:0] : DUR_WIDTH'(CHUNK_LIMIT);

   always_comb begin
      state_in         = state_ff;
      product_in       = product_ff;
      level_in         = level_ff;
      ticks_left_in    = ticks_left_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_tape_word_in = rsp_tape_word_ff;
      rsp_last_in      = rsp_last_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (pop_valid) begin
               product_in = PROD_WIDTH'(pop_entry.samples) * PROD_WIDTH'(ticks_per_sample);
               level_in   = pop_entry.level;
               state_in   = BK_SPLIT;
            end
         end
         BK_SPLIT: begin
            ticks_left_in = ticks_sat;
            state_in      = (ticks_sat == '0) ? BK_IDLE : BK_EMIT;
         end
         BK_EMIT: begin
            if (slot_free) begin
               rsp_valid_in     = 1'b1;
               rsp_tape_word_in = {~level_ff, chunk};
               rsp_last_in      = final_chunk;
               ticks_left_in    = ticks_left_ff - TPS_WIDTH'(chunk);
               if (final_chunk) begin
                  state_in = BK_IDLE;
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      product_ff       <= product_in;
      level_ff         <= level_in;
      ticks_left_ff    <= ticks_left_in;
      rsp_tape_word_ff <= rsp_tape_word_in;
      rsp_last_ff      <= rsp_last_in;
   end

endmodule
`default_nettype wire

/* hdl/level_run_length_tape_encoder_top.sv */
// top level of the level run-length tape encoder with its register port
// One level bit is taken per cycle while the two-entry run queue has room; a
// sample that repeats the level produces nothing. A level change queues the
// finished run; the back end then multiplies its sample count by the ticks
// per sample, scales and saturates the tick count, and emits the tape words
// (0 to 64 words, at most 32767 ticks each) one at a time as the output
// register frees up. The back end, one word at a time through the output
// register, sets the sustained rate. The final unfinished run is never sent.
// Register 0 at address 0 holds ticks per sample.
`default_nettype none
module level_run_length_tape_encoder_top (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    req_valid,
   output logic                                         req_ready,
   input  wire logic                                    req_level,
   output logic                                         rsp_valid,
   input  wire logic                                    rsp_ready,
   output logic [lrlte_pkg::WORD_WIDTH-1:0]             rsp_tape_word,
   output logic                                         rsp_last,
   input  wire logic                                    csr_psel,
   input  wire logic                                    csr_penable,
   input  wire logic                                    csr_pwrite,
   input  wire logic [lrlte_pkg::CSR_ADDR_WIDTH-1:0]    csr_paddr,
   input  wire logic [lrlte_pkg::CSR_DATA_WIDTH-1:0]    csr_pwdata,
   output logic [lrlte_pkg::CSR_DATA_WIDTH-1:0]         csr_prdata,
   output logic                                         csr_pready
);
   import lrlte_pkg::*;

   logic [TPS_WIDTH-1:0] tps_ff, tps_in;
   logic                 tps_write;
   logic                 push_valid, push_ready;
   run_entry_type        push_entry;
   logic                 pop_valid, pop_ready;
   run_entry_type        pop_entry;

   assign csr_pready = 1'b1;
   assign tps_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == CSR_IDX_TPS);
   assign tps_in     = tps_write ? csr_pwdata[TPS_WIDTH-1:0] : tps_ff;
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_TPS) ? CSR_DATA_WIDTH'(tps_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         tps_ff <= TPS_RESET;
      end else begin
         tps_ff <= tps_in;
      end
   end

   lrlte_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_level  (req_level),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   lrlte_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   lrlte_back u_back (
      .clock            (clock),
      .reset            (reset),
      .ticks_per_sample (tps_ff),
      .pop_valid        (pop_valid),
      .pop_ready        (pop_ready),
      .pop_entry        (pop_entry),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_tape_word    (rsp_tape_word),
      .rsp_last         (rsp_last)
   );

endmodule
`default_nettype wire
